/* rtl/crc8e_pkg.sv */
// Package for the configurable CRC-8 engine: widths, register indexes and
// the table entry function. No dependencies; imported by configurable_crc8_engine_top.
package crc8e_pkg;

  localparam int unsigned CrcW       = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned StateDepth = 1;
  localparam int unsigned StateAw    = 1;

  localparam logic [CrcW-1:0] CrcTopBit = 8'h80;

  typedef logic [CrcW-1:0]    crc_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t RegPoly    = 2'd0;
  localparam cfg_idx_t RegReflect = 2'd1;
  localparam cfg_idx_t RegInit    = 2'd2;
  localparam cfg_idx_t RegXorOut  = 2'd3;

  function automatic crc_t rev8(input crc_t v);
    crc_t r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

  // Eight MSB-first shift and XOR steps; in reflected mode the index and
  // the result are bit reversed around them.
  function automatic crc_t crc8_entry(input crc_t idx, input crc_t poly,
                                      input logic reflect);
    crc_t c;
    c = reflect ? rev8(idx) : idx;
    for (int i = 0; i < CrcW; i++) begin
      if ((c & CrcTopBit) != '0) begin
        c = {c[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return reflect ? rev8(c) : c;
  endfunction

endpackage

/* rtl/configurable_crc8_engine_top.sv */
// Top level of the configurable CRC-8 engine: input stage, state memory
// read-modify-write with forwarding, result register. Uses crc8e_pkg, crc8e_ram.
//
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  message byte, flags, resume value
// m_axis    out        m_axis_tvalid/m_axis_tready  finished CRC-8
// cfg       in         cfg_valid_i/cfg_ready_o      register index and data
//
// One byte is taken every cycle while the input side is not stalled; a result
// is registered once its last word leaves stage one. The running CRC sits in a
// one-entry memory with a registered read; writes during a read are forwarded.
// Reset clears the configuration to its defaults and the state to zero through
// a valid flag, so no clearing pass is needed. A stalled result register holds
// the input side only when the word in flight also carries a result.
module configurable_crc8_engine_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: resume_crc [7:0], data_byte [15:8]
  input  logic [15:0]           s_axis_tdata,
  // tuser: action [0], first_byte [1], empty_message [2]
  input  logic [2:0]            s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: crc_value [7:0]
  output logic [7:0]            m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  crc8e_pkg::cfg_idx_t   cfg_index_i,
  input  crc8e_pkg::crc_t       cfg_data_i
);
  import crc8e_pkg::*;

  // Configuration registers.
  crc_t poly_q, init_q, xor_out_q;
  logic reflect_q;

  // Stage one: accepted word waiting for its state read.
  logic s1_vld_q;
  logic s1_action_q, s1_first_q, s1_last_q, s1_empty_q;
  crc_t s1_resume_q, s1_data_q;
  logic fwd_hit_q, rd_vld_q;

  // State memory bookkeeping.
  logic mem_vld_q;
  crc_t fwd_q;
  crc_t ram_rdata;
  logic ram_we;

  // Result register.
  logic out_vld_q;
  crc_t out_crc_q, out_crc_d;

  logic acc_in, s1_res, s1_adv;
  crc_t prior_crc, start_crc, crc_next;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q    <= 8'h07;
      reflect_q <= 1'b0;
      init_q    <= '0;
      xor_out_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPoly:    poly_q    <= cfg_data_i;
        RegReflect: reflect_q <= cfg_data_i[0];
        RegInit:    init_q    <= cfg_data_i;
        RegXorOut:  xor_out_q <= cfg_data_i;
        default:    poly_q    <= poly_q;
      endcase
    end
  end

  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign s1_res        = s1_empty_q || s1_last_q;
  assign s1_adv        = s1_vld_q && (!s1_res || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign ram_we        = s1_adv && !s1_empty_q;

  crc8e_ram #(
    .Width (CrcW),
    .Depth (StateDepth)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (acc_in),
    .addr_i  ({StateAw{1'b0}}),
    .wdata_i (crc_next),
    .rdata_o (ram_rdata)
  );

  // A write in the cycle of the read is not seen by the memory read port,
  // and an entry never written reads as the reset value of zero.
  always_comb begin
    if (fwd_hit_q) begin
      prior_crc = fwd_q;
    end else if (rd_vld_q) begin
      prior_crc = ram_rdata;
    end else begin
      prior_crc = '0;
    end
    if (s1_first_q) begin
      start_crc = s1_action_q ? (s1_resume_q ^ xor_out_q) : init_q;
    end else begin
      start_crc = prior_crc;
    end
    crc_next = crc8_entry(start_crc ^ s1_data_q, poly_q, reflect_q);
    if (s1_empty_q) begin
      out_crc_d = s1_action_q ? s1_resume_q : init_q;
    end else begin
      out_crc_d = crc_next ^ xor_out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      mem_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc_in) begin
        s1_vld_q  <= 1'b1;
        fwd_hit_q <= ram_we;
        rd_vld_q  <= mem_vld_q;
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
      end
      if (ram_we) begin
        mem_vld_q <= 1'b1;
      end
      if (s1_adv && s1_res) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_resume_q <= s_axis_tdata[7:0];
      s1_data_q   <= s_axis_tdata[15:8];
      s1_action_q <= s_axis_tuser[0];
      s1_first_q  <= s_axis_tuser[1];
      s1_empty_q  <= s_axis_tuser[2];
      s1_last_q   <= s_axis_tlast;
    end
    if (ram_we) begin
      fwd_q <= crc_next;
    end
    if (s1_adv && s1_res) begin
      out_crc_q <= out_crc_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_crc_q;

  // The input side waits only behind a result that cannot leave.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_vld_q && s1_res && out_vld_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // Once a byte has been folded in, the state entry counts as written.
  a_state_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> mem_vld_q)
    else $error("state write not recorded");

  // A new result only ever comes from a word leaving stage one.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q && s1_res))
    else $error("result appeared without a finishing word");

endmodule

/* rtl/crc8e_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Standalone; used for the running CRC state of the engine.
module crc8e_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
